@@ rtl/core/sha1dc_pkg.sv @@
`default_nettype none

package sha1dc_pkg;

    localparam int NUM_DIGEST_WORDS = 5;
    localparam int NUM_BLOCK_WORDS  = 16;
    localparam int NUM_ROUNDS       = 80;
    localparam int CFG_INDEX_BITS   = 3;
    localparam int ROUND_BITS       = 7;
    localparam int WORD_INDEX_BITS  = 4;

    localparam logic [31:0] HASH_INIT [NUM_DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_ROUND_0 = 32'h5A827999;
    localparam logic [31:0] K_ROUND_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_ROUND_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_ROUND_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_ADD,
        ST_CMP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_req;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last;
        logic        untampered;
    } t_out_req;

endpackage

`default_nettype wire

@@ rtl/core/sha1_digest_with_compare.sv @@
`default_nettype none

// channel   direction  handshake                 payload
// in        request    i_in_valid / o_in_stall   i_in_req  (data_byte, last_byte)
// out       result     o_out_valid / i_out_stall o_out_req (digest_word, word_index,
//                                                 last, untampered)
// cfg       write      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// a byte that does not fill a block is taken while idle; the 64th byte of a block
// starts the round unit: 80 rounds, one per cycle, then the chain add.
// the last byte costs a padding state and one compression, or two when the length
// needs a block of its own (plus a load state), then a compare state and five
// result words. o_in_stall is high outside idle: through a block compression, and
// after the last byte until the fifth word leaves.
// reset is synchronous; it sets the chain value to HASH_INIT and clears the bit count and expected words.

module sha1_digest_with_compare
    import sha1dc_pkg::*;
#(
    parameter int LENGTH_BITS = 64
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire t_in_req             i_in_req,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output t_out_req                 o_out_req,
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire [31:0]               i_cfg_data
);

    localparam logic [ROUND_BITS-1:0] LAST_ROUND = ROUND_BITS'(NUM_ROUNDS - 1);
    localparam logic [2:0]            LAST_WORD  = 3'(NUM_DIGEST_WORDS - 1);

    t_state                  r_state;
    t_state                  n_state;
    logic [ROUND_BITS-1:0]   r_round;
    logic [LENGTH_BITS-1:0]  r_bit_count;
    logic                    r_msg_end;
    logic                    r_pad_done;
    logic                    r_len_pend;
    logic [2:0]              r_out_idx;
    logic                    r_untampered;
    logic [31:0]             r_h        [NUM_DIGEST_WORDS];
    logic [31:0]             r_expected [NUM_DIGEST_WORDS];
    logic [31:0]             r_w        [NUM_BLOCK_WORDS];
    logic [31:0]             r_a, r_b, r_c, r_d, r_e;

    logic                    in_fire;
    logic                    out_fire;
    logic                    cfg_fire;
    logic [5:0]              pos;
    logic [WORD_INDEX_BITS-1:0] pos_word;
    logic [1:0]              pos_lane;
    logic                    pos_high;
    logic [4:0]              lane_shift;
    logic [63:0]             len64;
    logic [31:0]             f_val;
    logic [31:0]             k_val;
    logic [31:0]             t_val;
    logic [31:0]             w_mix;
    logic [31:0]             w_next;
    logic                    all_equal;

    assign in_fire    = i_in_valid && !o_in_stall;
    assign out_fire   = o_out_valid && !i_out_stall;
    assign cfg_fire   = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;

    assign pos        = r_bit_count[8:3];
    assign pos_word   = pos[5:2];
    assign pos_lane   = pos[1:0];
    assign pos_high   = (pos[5:3] == 3'b111);
    assign lane_shift = {~pos_lane, 3'b000};
    assign len64      = 64'(r_bit_count);

    // round function
    always_comb begin
        case (r_round) inside
            [7'd0:7'd19]: begin
                f_val = (r_b & r_c) | (~r_b & r_d);
                k_val = K_ROUND_0;
            end
            [7'd20:7'd39]: begin
                f_val = r_b ^ r_c ^ r_d;
                k_val = K_ROUND_1;
            end
            [7'd40:7'd59]: begin
                f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
                k_val = K_ROUND_2;
            end
            default: begin
                f_val = r_b ^ r_c ^ r_d;
                k_val = K_ROUND_3;
            end
        endcase
        t_val  = {r_a[26:0], r_a[31:27]} + f_val + r_e + r_w[0] + k_val;
        w_mix  = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_next = {w_mix[30:0], w_mix[31]};
    end

    always_comb begin
        all_equal = 1'b1;
        for (int i = 0; i < NUM_DIGEST_WORDS; i++) begin
            if (r_h[i] != r_expected[i]) begin
                all_equal = 1'b0;
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (in_fire) begin
                    if (pos == 6'd63) begin
                        n_state = ST_ROUND;
                    end else if (i_in_req.last_byte) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: n_state = ST_ROUND;
            ST_LEN: n_state = ST_ROUND;
            ST_ROUND: begin
                if (r_round == LAST_ROUND) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (!r_msg_end) begin
                    n_state = ST_IDLE;
                end else if (!r_pad_done) begin
                    n_state = ST_PAD;
                end else if (r_len_pend) begin
                    n_state = ST_LEN;
                end else begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: n_state = ST_OUT;
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (out_fire && r_out_idx == LAST_WORD) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control and chain state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round      <= '0;
            r_bit_count  <= '0;
            r_msg_end    <= 1'b0;
            r_pad_done   <= 1'b0;
            r_len_pend   <= 1'b0;
            r_out_idx    <= '0;
            r_untampered <= 1'b0;
            for (int i = 0; i < NUM_DIGEST_WORDS; i++) begin
                r_h[i]        <= HASH_INIT[i];
                r_expected[i] <= '0;
            end
        end else begin
            r_round <= (r_state == ST_ROUND) ? r_round + 1'b1 : '0;
            if (cfg_fire && i_cfg_index < 3'(NUM_DIGEST_WORDS)) begin
                r_expected[i_cfg_index] <= i_cfg_data;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_bit_count <= r_bit_count + LENGTH_BITS'(8);
                        r_msg_end   <= i_in_req.last_byte;
                        r_pad_done  <= 1'b0;
                        r_len_pend  <= 1'b0;
                    end
                end
                ST_PAD: begin
                    r_pad_done <= 1'b1;
                    r_len_pend <= pos_high;
                end
                ST_LEN: r_len_pend <= 1'b0;
                ST_ADD: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                end
                ST_CMP: begin
                    r_untampered <= all_equal;
                    r_out_idx    <= '0;
                end
                ST_OUT: begin
                    if (out_fire) begin
                        r_out_idx <= r_out_idx + 1'b1;
                        if (r_out_idx == LAST_WORD) begin
                            r_bit_count <= '0;
                            r_msg_end   <= 1'b0;
                            for (int i = 0; i < NUM_DIGEST_WORDS; i++) begin
                                r_h[i] <= HASH_INIT[i];
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // block buffer, schedule and working variables
    always_ff @(posedge i_clk) begin
        if (r_state == ST_ROUND) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= t_val;
            for (int i = 0; i < NUM_BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[NUM_BLOCK_WORDS - 1] <= w_next;
        end else begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end
        if (r_state == ST_IDLE && in_fire) begin
            if (pos_lane == 2'd0) begin
                r_w[pos_word] <= 32'(i_in_req.data_byte) << lane_shift;
            end else begin
                r_w[pos_word] <= r_w[pos_word] | (32'(i_in_req.data_byte) << lane_shift);
            end
        end
        if (r_state == ST_PAD) begin
            for (int i = 0; i < NUM_BLOCK_WORDS; i++) begin
                if (WORD_INDEX_BITS'(i) == pos_word) begin
                    if (pos_lane == 2'd0) begin
                        r_w[i] <= 32'(PAD_BYTE) << lane_shift;
                    end else begin
                        r_w[i] <= r_w[i] | (32'(PAD_BYTE) << lane_shift);
                    end
                end else if (WORD_INDEX_BITS'(i) > pos_word &&
                             (pos_high || i < NUM_BLOCK_WORDS - 2)) begin
                    r_w[i] <= '0;
                end
            end
            if (!pos_high) begin
                r_w[NUM_BLOCK_WORDS - 2] <= len64[63:32];
                r_w[NUM_BLOCK_WORDS - 1] <= len64[31:0];
            end
        end
        if (r_state == ST_LEN) begin
            for (int i = 0; i < NUM_BLOCK_WORDS - 2; i++) begin
                r_w[i] <= '0;
            end
            r_w[NUM_BLOCK_WORDS - 2] <= len64[63:32];
            r_w[NUM_BLOCK_WORDS - 1] <= len64[31:0];
        end
    end

    assign o_out_req.digest_word = r_h[r_out_idx];
    assign o_out_req.word_index  = r_out_idx;
    assign o_out_req.last        = (r_out_idx == LAST_WORD);
    assign o_out_req.untampered  = r_untampered;

endmodule

`default_nettype wire
